FILE: sv/rfb_pkg.sv
// Package: shared constants, codes and types for the record filter bitmap.
`default_nettype none
package rfb_pkg;

  // Bitmap geometry: rows of ROW_W bits in a RAM with one write port and one read port.
  localparam int MAX_IDS = 4096;
  localparam int IDX_W   = $clog2(MAX_IDS);
  localparam int CNT_W   = IDX_W + 1;
  localparam int ROW_W   = 32;
  localparam int BIT_W   = $clog2(ROW_W);
  localparam int ROWS    = MAX_IDS / ROW_W;
  localparam int ROW_AW  = $clog2(ROWS);

  // Item queue between front and back.
  localparam int QDEPTH  = 2;
  localparam int QA_W    = $clog2(QDEPTH);
  localparam int QC_W    = $clog2(QDEPTH + 1);

  // Function codes.
  localparam logic [2:0] FN_APPLY  = 3'd0;
  localparam logic [2:0] FN_TEST   = 3'd1;
  localparam logic [2:0] FN_SET    = 3'd2;
  localparam logic [2:0] FN_UNSET  = 3'd3;
  localparam logic [2:0] FN_CLEAR  = 3'd4;
  localparam logic [2:0] FN_SETALL = 3'd5;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_IDS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOW_TIME = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AS_OF    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRED_EN  = 3'd4;

  // Predicate enable bits.
  localparam int PRED_QUAR     = 0;
  localparam int PRED_TTL      = 1;
  localparam int PRED_NOT_VIS  = 2;
  localparam int PRED_INACTIVE = 3;
  localparam int PRED_VERSION  = 4;
  localparam int PRED_TT_VIS   = 5;
  localparam int PRED_TT_FROM  = 6;
  localparam int PRED_W        = 7;

  typedef struct packed {
    logic        [CNT_W-1:0]  num_ids;
    logic signed [63:0]       now_time;
    logic signed [63:0]       as_of_time;
    logic signed [31:0]       ver_floor;
    logic        [PRED_W-1:0] pred_en;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       func;
    logic [IDX_W-1:0] index;
    logic             fired;
  } q_item_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_EXEC,
    B_SWEEP,
    B_FIN
  } back_state_t;

endpackage
`default_nettype wire

FILE: sv/rfb_ram.sv
// Generic single-port-write RAM with registered read.
`default_nettype none
module rfb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: sv/rfb_queue.sv
// Short item queue between the classifier and the bitmap engine.
`default_nettype none
module rfb_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire rfb_pkg::q_item_t push_item,
  output logic                  full,
  input  wire logic             pop,
  output rfb_pkg::q_item_t      head,
  output logic                  head_valid
);
  import rfb_pkg::*;

  q_item_t             slots [QDEPTH];
  logic [QA_W-1:0]     wr_ptr;
  logic [QA_W-1:0]     rd_ptr;
  logic [QC_W-1:0]     fill;

  assign full       = (fill == QC_W'(QDEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QA_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QA_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

FILE: sv/rfb_front.sv
// Front end: accepts beats and evaluates the record predicates.
`default_nettype none
module rfb_front (
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         func,
  input  wire logic [rfb_pkg::IDX_W-1:0] index,
  input  wire logic               quarantined,
  input  wire logic               active,
  input  wire logic signed [63:0] ttl_time,
  input  wire logic signed [63:0] visible_time,
  input  wire logic signed [63:0] valid_from_time,
  input  wire logic signed [31:0] version,
  input  wire rfb_pkg::cfg_t      cfg,
  input  wire logic               q_full,
  output logic                    push,
  output rfb_pkg::q_item_t        item
);
  import rfb_pkg::*;

  logic [PRED_W-1:0] hit;
  logic              any_hit;

  always_comb begin
    hit                = '0;
    hit[PRED_QUAR]     = quarantined;
    hit[PRED_TTL]      = ($signed(ttl_time) > 64'sd0) &&
                         ($signed(ttl_time) < $signed(cfg.now_time));
    hit[PRED_NOT_VIS]  = $signed(visible_time) > $signed(cfg.now_time);
    hit[PRED_INACTIVE] = !active;
    hit[PRED_VERSION]  = $signed(version) < $signed(cfg.ver_floor);
    hit[PRED_TT_VIS]   = $signed(visible_time) > $signed(cfg.as_of_time);
    hit[PRED_TT_FROM]  = $signed(valid_from_time) > $signed(cfg.as_of_time);
  end

  assign any_hit    = |(hit & cfg.pred_en);
  assign in_ready   = !q_full;
  assign push       = in_valid && in_ready;
  assign item.func  = func;
  assign item.index = index;
  assign item.fired = (func == FN_APPLY) && any_hit;

endmodule
`default_nettype wire

FILE: sv/rfb_back.sv
// Back end: bitmap RAM, row valid flags, set-bit counter and result register.
`default_nettype none
module rfb_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rfb_pkg::q_item_t     q_head,
  input  wire logic                 q_valid,
  output logic                      q_pop,
  input  wire rfb_pkg::cfg_t        cfg,
  input  wire logic                 clr_store,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      filtered,
  output logic                      fired,
  output logic [rfb_pkg::CNT_W-1:0] filtered_count
);
  import rfb_pkg::*;

  back_state_t       state, state_next;
  q_item_t           cur;
  logic [ROW_AW-1:0] sweep_row;
  logic [ROWS-1:0]   row_valid;
  logic [CNT_W-1:0]  set_count;
  logic [CNT_W-1:0]  count_next;

  logic [CNT_W-1:0]  bound;
  logic [ROW_AW-1:0] cur_row;
  logic [BIT_W-1:0]  cur_bit;
  logic              in_range;
  logic [ROW_W-1:0]  ram_rdata;
  logic [ROW_W-1:0]  old_row;
  logic [ROW_W-1:0]  new_row;
  logic              old_bit;
  logic              new_bit;
  logic              wr_op;
  logic              upd;
  logic              slot_free;
  logic [CNT_W-1:0]  base;
  logic [CNT_W-1:0]  rem;
  logic [ROW_W-1:0]  sweep_mask;
  logic              last_row;

  logic              ram_we;
  logic [ROW_AW-1:0] ram_waddr;
  logic [ROW_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ROW_AW-1:0] ram_raddr;
  logic              load_out;
  logic              res_filtered;
  logic              res_fired;

  assign bound     = (cfg.num_ids > CNT_W'(MAX_IDS)) ? CNT_W'(MAX_IDS) : cfg.num_ids;
  assign cur_row   = cur.index[IDX_W-1:BIT_W];
  assign cur_bit   = cur.index[BIT_W-1:0];
  assign in_range  = {1'b0, cur.index} < bound;
  // rows never written since the last clear read as zero
  assign old_row   = row_valid[cur_row] ? ram_rdata : '0;
  assign old_bit   = old_row[cur_bit];
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    case (cur.func)
      FN_APPLY: new_bit = cur.fired ? 1'b1 : old_bit;
      FN_SET:   new_bit = 1'b1;
      FN_UNSET: new_bit = 1'b0;
      FN_CLEAR: new_bit = 1'b0;
      default:  new_bit = old_bit;
    endcase
  end

  assign wr_op = (cur.func == FN_APPLY) || (cur.func == FN_SET) || (cur.func == FN_UNSET);
  assign upd   = in_range && wr_op && (new_bit != old_bit);

  always_comb begin
    new_row          = old_row;
    new_row[cur_bit] = new_bit;
  end

  // set-all row mask: ones for ids below the bound
  assign base     = {1'b0, sweep_row, {BIT_W{1'b0}}};
  assign rem      = bound - base;
  assign last_row = (sweep_row == ROW_AW'(ROWS - 1));

  always_comb begin
    if (bound >= base + CNT_W'(ROW_W)) begin
      sweep_mask = '1;
    end else if (bound <= base) begin
      sweep_mask = '0;
    end else begin
      sweep_mask = ~({ROW_W{1'b1}} << rem[BIT_W-1:0]);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          state_next = (q_head.func == FN_SETALL) ? B_SWEEP : B_EXEC;
        end
      end
      B_EXEC: begin
        if (slot_free) begin
          state_next = B_IDLE;
        end
      end
      B_SWEEP: begin
        if (last_row) begin
          state_next = B_FIN;
        end
      end
      B_FIN: begin
        if (slot_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop        = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = q_head.index[IDX_W-1:BIT_W];
    ram_we       = 1'b0;
    ram_waddr    = cur_row;
    ram_wdata    = new_row;
    load_out     = 1'b0;
    res_filtered = !in_range || new_bit;
    res_fired    = 1'b0;
    count_next   = set_count;
    unique case (state)
      B_IDLE: begin
        q_pop  = q_valid;
        ram_re = q_valid;
      end
      B_EXEC: begin
        if (slot_free) begin
          load_out  = 1'b1;
          ram_we    = upd;
          res_fired = cur.fired;
          if (cur.func == FN_CLEAR) begin
            count_next = '0;
          end else if (upd) begin
            count_next = new_bit ? set_count + 1'b1 : set_count - 1'b1;
          end
        end
      end
      B_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_row;
        ram_wdata = sweep_mask;
      end
      B_FIN: begin
        res_filtered = 1'b1;
        if (slot_free) begin
          load_out   = 1'b1;
          count_next = bound;
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  rfb_ram #(
    .WIDTH(ROW_W),
    .DEPTH(ROWS)
  ) u_bits (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      row_valid <= '0;
      set_count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clr_store) begin
        row_valid <= '0;
        set_count <= '0;
      end else begin
        set_count <= count_next;
        if (state == B_EXEC && slot_free && cur.func == FN_CLEAR) begin
          row_valid <= '0;
        end else if (ram_we) begin
          row_valid[ram_waddr] <= 1'b1;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur       <= q_head;
      sweep_row <= '0;
    end else if (state == B_SWEEP) begin
      sweep_row <= sweep_row + 1'b1;
    end
    if (load_out) begin
      filtered       <= res_filtered;
      fired          <= res_fired;
      filtered_count <= count_next;
    end
  end

  a_count_in_bound: assert property (@(posedge clk) disable iff (rst)
    set_count <= bound)
    else $error("set count above bound");

  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!out_valid || out_ready))
    else $error("result overwrote a pending beat");

  a_sweep_ends: assert property (@(posedge clk) disable iff (rst)
    (state == B_SWEEP && last_row) |=> (state == B_FIN))
    else $error("set-all sweep did not finish");

endmodule
`default_nettype wire

FILE: sv/record_filter_bitmap_unit.sv
// Top level: record exclusion bitmap with predicate filter and set-bit count.
// Flow: an accepted beat is queued, popped with a read of its bitmap RAM row, executed and
//   its result registered (test, set, unset, apply, clear-all); set-all sweeps all ROWS rows (one row per cycle).
// The back end finishes the read-modify-write of one item's row before it pops the next item.
// Reset: per-row valid flags clear the whole bitmap at once; no clearing pass.
// Writing num_ids clears the bitmap and count in the same way.
`default_nettype none
module record_filter_bitmap_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [2:0]                        func,
  input  wire logic [rfb_pkg::IDX_W-1:0]         index,
  input  wire logic                              quarantined,
  input  wire logic                              active,
  input  wire logic signed [63:0]                ttl_time,
  input  wire logic signed [63:0]                visible_time,
  input  wire logic signed [63:0]                valid_from_time,
  input  wire logic signed [31:0]                version,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   filtered,
  output logic                                   fired,
  output logic [rfb_pkg::CNT_W-1:0]              filtered_count,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rfb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [63:0]                       cfg_data
);
  import rfb_pkg::*;

  cfg_t    cfg;
  logic    clr_store;
  logic    q_full;
  logic    push;
  q_item_t push_item;
  q_item_t q_head;
  logic    q_valid;
  logic    q_pop;

  assign cfg_ready = 1'b1;
  assign clr_store = cfg_valid && (cfg_index == REG_NUM_IDS);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_NUM_IDS:  cfg.num_ids     <= cfg_data[CNT_W-1:0];
        REG_NOW_TIME: cfg.now_time    <= $signed(cfg_data);
        REG_AS_OF:    cfg.as_of_time  <= $signed(cfg_data);
        REG_MIN_VER:  cfg.ver_floor   <= $signed(cfg_data[31:0]);
        REG_PRED_EN:  cfg.pred_en     <= cfg_data[PRED_W-1:0];
        default:      cfg             <= cfg;
      endcase
    end
  end

  rfb_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .index          (index),
    .quarantined    (quarantined),
    .active         (active),
    .ttl_time       (ttl_time),
    .visible_time   (visible_time),
    .valid_from_time(valid_from_time),
    .version        (version),
    .cfg            (cfg),
    .q_full         (q_full),
    .push           (push),
    .item           (push_item)
  );

  rfb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .head_valid(q_valid)
  );

  rfb_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_head        (q_head),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .cfg           (cfg),
    .clr_store     (clr_store),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .filtered      (filtered),
    .fired         (fired),
    .filtered_count(filtered_count)
  );

endmodule
`default_nettype wire

FILE: tb/sv/record_filter_bitmap_unit_tb.sv
// Testbench for record_filter_bitmap_unit: predicted bitmap verdicts checked beat by beat.
`timescale 1ns / 100ps
module record_filter_bitmap_unit_tb;
  import rfb_pkg::*;

  localparam logic [2:0] FN_SPARE6 = 3'd6;
  localparam logic [2:0] FN_SPARE7 = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE5 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;
  localparam int IDLE_LIMIT  = 4000;
  localparam int LONG_HOLD   = 400;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 123;
  localparam logic signed [63:0] T_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] T_MIN = {1'b1, 63'd0};
  localparam logic signed [31:0] V_MAX = {1'b0, {31{1'b1}}};
  localparam logic signed [31:0] V_MIN = {1'b1, 31'd0};

  typedef struct packed {
    logic             filt;
    logic             fired;
    logic [CNT_W-1:0] count;
  } verdict_t;

  logic clk, rst;
  logic in_valid, in_ready;
  logic [2:0] func;
  logic [IDX_W-1:0] index;
  logic quarantined, active;
  logic signed [63:0] ttl_time, visible_time, valid_from_time;
  logic signed [31:0] version;
  logic out_valid, out_ready;
  logic filtered, fired;
  logic [CNT_W-1:0] filtered_count;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0] cfg_data;

  record_filter_bitmap_unit DUT (.*);

  // Exclusion bitmap predictor plus the queue of verdicts still owed by the block.
  class exclusion_model;
    bit excl [MAX_IDS];
    logic [CNT_W-1:0] set_bits;
    logic [CNT_W-1:0] num_ids;
    logic signed [63:0] now_time, as_of_time;
    logic signed [31:0] ver_floor;
    logic [PRED_W-1:0] pred_en;
    verdict_t pending_verdicts[$];
    int mismatches;

    function new();
      clear_bits();
      num_ids = '0;
      now_time = '0;
      as_of_time = '0;
      ver_floor = '0;
      pred_en = '0;
      mismatches = 0;
    endfunction

    function void clear_bits();
      for (int i = 0; i < MAX_IDS; i++) excl[i] = 1'b0;
      set_bits = '0;
    endfunction

    function int unsigned bound();
      return (num_ids > MAX_IDS) ? MAX_IDS : int'(num_ids);
    endfunction

    function void write_bit(int unsigned i, bit v);
      if (i >= bound()) return;
      if (excl[i] != v) begin
        excl[i] = v;
        if (v) set_bits++;
        else set_bits--;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] ri, logic [63:0] d);
      case (ri)
        REG_NUM_IDS: begin
          num_ids = d[CNT_W-1:0];
          clear_bits();
        end
        REG_NOW_TIME: now_time = d;
        REG_AS_OF:    as_of_time = d;
        REG_MIN_VER:  ver_floor = d[31:0];
        REG_PRED_EN:  pred_en = d[PRED_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(logic [2:0] f, logic [IDX_W-1:0] ix, logic q, logic a,
                            logic signed [63:0] ttl, logic signed [63:0] vis,
                            logic signed [63:0] vfrom, logic signed [31:0] ver);
      bit hit;
      verdict_t v;
      hit = 1'b0;
      case (f)
        FN_APPLY: begin
          if (pred_en[PRED_QUAR] && q) hit = 1'b1;
          if (pred_en[PRED_TTL] && ttl > 0 && ttl < now_time) hit = 1'b1;
          if (pred_en[PRED_NOT_VIS] && vis > now_time) hit = 1'b1;
          if (pred_en[PRED_INACTIVE] && !a) hit = 1'b1;
          if (pred_en[PRED_VERSION] && ver < ver_floor) hit = 1'b1;
          if (pred_en[PRED_TT_VIS] && vis > as_of_time) hit = 1'b1;
          if (pred_en[PRED_TT_FROM] && vfrom > as_of_time) hit = 1'b1;
          if (hit) write_bit(ix, 1'b1);
        end
        FN_SET:   write_bit(ix, 1'b1);
        FN_UNSET: write_bit(ix, 1'b0);
        FN_CLEAR: clear_bits();
        FN_SETALL: begin
          for (int i = 0; i < bound(); i++) excl[i] = 1'b1;
          set_bits = CNT_W'(bound());
        end
        default: ;
      endcase
      v.filt = (ix >= bound()) ? 1'b1 : excl[ix];
      v.fired = hit;
      v.count = set_bits;
      pending_verdicts.push_back(v);
    endfunction

    function void check_verdict(logic filt, logic fr, logic [CNT_W-1:0] count);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: filtered=%0b fired=%0b count=%0d",
                   filt, fr, count);
        return;
      end
      want = pending_verdicts.pop_front();
      if (want.filt !== filt || want.fired !== fr || want.count !== count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected filtered=%0b fired=%0b count=%0d, got %0b %0b %0d",
                   want.filt, want.fired, want.count, filt, fr, count);
      end
    endfunction
  endclass

  exclusion_model bitmap = new();
  bit stalls_on = 1'b1;
  bit hold_req = 1'b0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) bitmap.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready)
        bitmap.note_item(func, index, quarantined, active, ttl_time, visible_time,
                         valid_from_time, version);
      if (out_valid && out_ready) bitmap.check_verdict(filtered, fired, filtered_count);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
    begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("record_filter_bitmap_unit test failed");
        $finish;
      end
    end
  end

  // Result side: random stall bursts, one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic [2:0] f, input logic [IDX_W-1:0] ix,
                           input logic q, input logic a,
                           input logic signed [63:0] ttl, input logic signed [63:0] vis,
                           input logic signed [63:0] vfrom, input logic signed [31:0] ver);
    if (stalls_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    func <= f;
    index <= ix;
    quarantined <= q;
    active <= a;
    ttl_time <= ttl;
    visible_time <= vis;
    valid_from_time <= vfrom;
    version <= ver;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Clean record: nothing fires under the directed settings.
  task automatic bit_op(input logic [2:0] f, input logic [IDX_W-1:0] ix);
    send_item(f, ix, 1'b0, 1'b1, 64'sd0, 64'sd0, 64'sd0, 32'sd10);
  endtask

  task automatic apply_rec(input logic [IDX_W-1:0] ix, input logic q, input logic a,
                           input logic signed [63:0] ttl, input logic signed [63:0] vis,
                           input logic signed [63:0] vfrom, input logic signed [31:0] ver);
    send_item(FN_APPLY, ix, q, a, ttl, vis, vfrom, ver);
  endtask

  // Stop offering, wait for every owed verdict, then let the back end settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (bitmap.pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [CNT_W-1:0] n, input logic signed [63:0] now_t,
                           input logic signed [63:0] as_of, input logic signed [31:0] min_v,
                           input logic [PRED_W-1:0] en);
    logic [63:0] d;
    // Upper bits above each register's width are junk on purpose.
    for (int k = 0; k < 6; k++) begin
      d = {$urandom, $urandom};
      case (k)
        0: begin
          cfg_index <= REG_NUM_IDS;
          d[CNT_W-1:0] = n;
        end
        1: begin
          cfg_index <= REG_NOW_TIME;
          d = now_t;
        end
        2: begin
          cfg_index <= REG_AS_OF;
          d = as_of;
        end
        3: begin
          cfg_index <= REG_MIN_VER;
          d[31:0] = min_v;
        end
        4: begin
          cfg_index <= REG_PRED_EN;
          d[PRED_W-1:0] = en;
        end
        default: cfg_index <= CFG_IDX_W'($urandom_range(REG_SPARE5, REG_SPARE7));
      endcase
      cfg_data <= d;
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [63:0] near64(input logic signed [63:0] c);
    case ($urandom_range(0, 6))
      0:       return c;
      1, 2:    return c + $signed(64'($urandom_range(0, 6))) - 64'sd3;
      3:       return 64'sd0;
      4:       return T_MAX;
      5:       return T_MIN;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic signed [31:0] near32(input logic signed [31:0] c);
    case ($urandom_range(0, 5))
      0:       return c;
      1, 2:    return c + $signed(32'($urandom_range(0, 6))) - 32'sd3;
      3:       return V_MAX;
      4:       return V_MIN;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_item();
    logic [2:0] f;
    logic [IDX_W-1:0] ix;
    logic signed [63:0] vis;
    int unsigned bnd, r;
    r = $urandom_range(0, 99);
    if (r < 42) f = FN_APPLY;
    else if (r < 58) f = FN_TEST;
    else if (r < 72) f = FN_SET;
    else if (r < 86) f = FN_UNSET;
    else if (r < 91) f = FN_CLEAR;
    else if (r < 94) f = FN_SETALL;
    else if (r < 97) f = FN_SPARE6;
    else f = FN_SPARE7;
    bnd = bitmap.bound();
    if (bnd > 0 && $urandom_range(0, 4) != 0) ix = IDX_W'($urandom_range(0, bnd - 1));
    else ix = IDX_W'($urandom);
    vis = near64($urandom_range(0, 1) ? bitmap.now_time : bitmap.as_of_time);
    send_item(f, ix, 1'($urandom), 1'($urandom), near64(bitmap.now_time), vis,
              near64(bitmap.as_of_time), near32(bitmap.ver_floor));
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    func = FN_TEST;
    index = '0;
    quarantined = 1'b0;
    active = 1'b1;
    ttl_time = '0;
    visible_time = '0;
    valid_from_time = '0;
    version = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_NUM_IDS;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: 16 ids, now 1000, as-of 500, version floor 10, all predicates on.
    configure(13'd16, 64'sd1000, 64'sd500, 32'sd10, 7'h7F);
    bit_op(FN_TEST, 12'd0);
    bit_op(FN_TEST, 12'hFFF);
    bit_op(FN_TEST, 12'd16);
    bit_op(FN_SET, 12'd3);
    bit_op(FN_TEST, 12'd3);
    bit_op(FN_UNSET, 12'd3);
    bit_op(FN_UNSET, 12'd3);
    bit_op(FN_SET, 12'd16);
    apply_rec(12'd5, 1'b0, 1'b1, 64'sd0, 64'sd0, 64'sd0, 32'sd10);
    apply_rec(12'd5, 1'b1, 1'b1, 64'sd0, 64'sd0, 64'sd0, 32'sd10);
    apply_rec(12'd6, 1'b0, 1'b1, 64'sd999, 64'sd0, 64'sd0, 32'sd10);
    apply_rec(12'd7, 1'b0, 1'b1, -64'sd5, 64'sd0, 64'sd0, 32'sd10);
    apply_rec(12'd7, 1'b0, 1'b1, 64'sd1000, 64'sd0, 64'sd0, 32'sd10);
    apply_rec(12'd8, 1'b0, 1'b1, 64'sd0, 64'sd2000, 64'sd0, 32'sd10);
    apply_rec(12'd9, 1'b0, 1'b1, 64'sd0, 64'sd700, 64'sd0, 32'sd10);
    apply_rec(12'd10, 1'b0, 1'b0, 64'sd0, 64'sd0, 64'sd0, 32'sd10);
    apply_rec(12'd11, 1'b0, 1'b1, 64'sd0, 64'sd0, 64'sd0, 32'sd9);
    apply_rec(12'd12, 1'b0, 1'b1, 64'sd0, 64'sd0, 64'sd501, 32'sd10);
    // fires but the index is past the bound, so the store is untouched
    apply_rec(12'hFFF, 1'b1, 1'b1, 64'sd0, 64'sd0, 64'sd0, 32'sd10);
    bit_op(FN_SETALL, 12'd0);
    bit_op(FN_TEST, 12'd15);
    bit_op(FN_SPARE6, 12'd2);
    bit_op(FN_SPARE7, 12'hFFF);
    bit_op(FN_CLEAR, 12'd0);
    apply_rec(12'd15, 1'b1, 1'b0, T_MAX, T_MIN, T_MIN, V_MIN);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) stalls_on = 1'b0;
      case (p)
        0: configure(13'(MAX_IDS), T_MAX, T_MIN, V_MIN, 7'h7F);
        1: configure(13'd0, T_MIN, T_MAX, V_MAX, 7'h00);
        2: configure(13'h1FFF, 64'sd0, 64'sd0, 32'sd0, PRED_W'($urandom));
        3: configure(13'd1, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                     PRED_W'($urandom));
        default: configure(($urandom_range(0, 2) != 0) ? 13'($urandom_range(1, 64))
                                                       : 13'($urandom_range(0, 8191)),
                           near64(64'sd0), near64(64'sd0), near32(32'sd0),
                           PRED_W'($urandom));
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 4 && k == 20) hold_req = 1'b1;
        random_item();
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (bitmap.mismatches == 0 && bitmap.pending_verdicts.size() == 0) begin
      $display("record_filter_bitmap_unit test passed");
    end else begin
      $display("record_filter_bitmap_unit test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/rfb_pkg.sv
sv/rfb_ram.sv
sv/rfb_queue.sv
sv/rfb_front.sv
sv/rfb_back.sv
sv/record_filter_bitmap_unit.sv
tb/sv/record_filter_bitmap_unit_tb.sv
